FILE: rtl/adq_pkg.sv
// adq_pkg: shared types and constants of the array double-ended queue
// used by the channel interfaces and the array_double_ended_queue top level
package adq_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int CAP_W     = 7;
    localparam int CMP_W     = (ADDR_W + 1 > CAP_W) ? ADDR_W + 1 : CAP_W;
    localparam int DATA_W    = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_REAR  = 2'd1,
        OP_REM_FRONT = 2'd2,
        OP_REM_REAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_EMPTY   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

endpackage

FILE: rtl/adq_op_if.sv
// adq_op_if: operation channel, valid/ready with operation and insert value
// depends on adq_pkg
interface adq_op_if;
    logic                             valid;
    logic                             ready;
    adq_pkg::t_op                     operation;
    logic signed [adq_pkg::DATA_W-1:0] insert_value;

    modport source (output valid, output operation, output insert_value, input ready);
    modport sink   (input valid, input operation, input insert_value, output ready);
endinterface

FILE: rtl/adq_res_if.sv
// adq_res_if: result channel, valid/ready with removed value and status
// depends on adq_pkg
interface adq_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [adq_pkg::DATA_W-1:0] removed_value;
    adq_pkg::t_status                 status;

    modport source (output valid, output removed_value, output status, input ready);
    modport sink   (input valid, input removed_value, input status, output ready);
endinterface

FILE: rtl/array_double_ended_queue.sv
// array_double_ended_queue: linear array deque with front and rear indices
// depends on adq_pkg, adq_op_if and adq_res_if
//
//  channel   direction  content
//  i_op      in         operation, insert_value
//  o_res     out        removed_value, status
//  i_cfg_*   in         capacity write, no read-back
//
//  an insert or a failed operation registers its result directly; a successful removal
//  first passes the registered read of the slot memory and the S_READ state
//  a new operation is taken while a result waits if that result leaves in the same cycle
//  reset zeroes indices, sets empty flag, capacity 64, idle handshake; slots untouched
module array_double_ended_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [adq_pkg::CAP_W-1:0]   i_cfg_data,
    adq_op_if.sink                      i_op,
    adq_res_if.source                   o_res
);

    logic [adq_pkg::DATA_W-1:0] r_mem [adq_pkg::MAX_SLOTS];

    adq_pkg::t_state             r_state, n_state;
    logic [adq_pkg::ADDR_W-1:0]  r_front, n_front;
    logic [adq_pkg::ADDR_W-1:0]  r_rear, n_rear;
    logic                        r_empty, n_empty;
    logic [adq_pkg::CAP_W-1:0]   r_cap;
    logic                        r_out_valid, n_out_valid;
    logic [adq_pkg::DATA_W-1:0]  r_removed, n_removed;
    adq_pkg::t_status            r_status, n_status;
    logic [adq_pkg::DATA_W-1:0]  r_rd_data;

    logic                        wr_en;
    logic [adq_pkg::ADDR_W-1:0]  wr_addr;
    logic                        rd_en;
    logic [adq_pkg::ADDR_W-1:0]  rd_addr;
    logic                        accept;
    logic [adq_pkg::CMP_W-1:0]   cap_ext;
    logic [adq_pkg::CMP_W-1:0]   eff_cap;
    logic [adq_pkg::CMP_W-1:0]   rear_next;

    assign i_op.ready = (r_state == adq_pkg::S_IDLE) && (!r_out_valid || o_res.ready);
    assign accept     = i_op.valid && i_op.ready;

    assign o_res.valid         = r_out_valid;
    assign o_res.removed_value = r_removed;
    assign o_res.status        = r_status;

    // effective capacity clamped to 1..MAX_SLOTS
    assign cap_ext   = adq_pkg::CMP_W'(r_cap);
    assign rear_next = adq_pkg::CMP_W'(r_rear) + adq_pkg::CMP_W'(1);
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = adq_pkg::CMP_W'(1);
        end else if (cap_ext > adq_pkg::CMP_W'(adq_pkg::MAX_SLOTS)) begin
            eff_cap = adq_pkg::CMP_W'(adq_pkg::MAX_SLOTS);
        end else begin
            eff_cap = cap_ext;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_rear      = r_rear;
        n_empty     = r_empty;
        n_out_valid = r_out_valid;
        n_removed   = r_removed;
        n_status    = r_status;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            adq_pkg::S_IDLE: begin
                if (accept) begin
                    n_removed   = '0;
                    n_status    = adq_pkg::ST_DONE;
                    n_out_valid = 1'b1;
                    case (i_op.operation)
                        adq_pkg::OP_INS_FRONT: begin
                            if (r_empty) begin
                                n_front = '0;
                                n_rear  = '0;
                                n_empty = 1'b0;
                                wr_en   = 1'b1;
                                wr_addr = '0;
                            end else if (r_front != '0) begin
                                n_front = r_front - adq_pkg::ADDR_W'(1);
                                wr_en   = 1'b1;
                                wr_addr = r_front - adq_pkg::ADDR_W'(1);
                            end else begin
                                n_status = adq_pkg::ST_NO_ROOM;
                            end
                        end
                        adq_pkg::OP_INS_REAR: begin
                            if (r_empty) begin
                                n_front = '0;
                                n_rear  = '0;
                                n_empty = 1'b0;
                                wr_en   = 1'b1;
                                wr_addr = '0;
                            end else if (rear_next >= eff_cap) begin
                                n_status = adq_pkg::ST_NO_ROOM;
                            end else begin
                                n_rear  = r_rear + adq_pkg::ADDR_W'(1);
                                wr_en   = 1'b1;
                                wr_addr = r_rear + adq_pkg::ADDR_W'(1);
                            end
                        end
                        adq_pkg::OP_REM_FRONT: begin
                            if (r_empty) begin
                                n_status = adq_pkg::ST_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = r_front;
                                n_out_valid = 1'b0;
                                n_state     = adq_pkg::S_READ;
                                if (r_front == r_rear) begin
                                    n_front = '0;
                                    n_rear  = '0;
                                    n_empty = 1'b1;
                                end else begin
                                    n_front = r_front + adq_pkg::ADDR_W'(1);
                                end
                            end
                        end
                        adq_pkg::OP_REM_REAR: begin
                            if (r_empty) begin
                                n_status = adq_pkg::ST_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = r_rear;
                                n_out_valid = 1'b0;
                                n_state     = adq_pkg::S_READ;
                                if (r_front == r_rear) begin
                                    n_front = '0;
                                    n_rear  = '0;
                                    n_empty = 1'b1;
                                end else begin
                                    n_rear = r_rear - adq_pkg::ADDR_W'(1);
                                end
                            end
                        end
                        default: begin
                            n_status = adq_pkg::ST_EMPTY;
                        end
                    endcase
                end
            end
            adq_pkg::S_READ: begin
                // output register is free here, it was free or leaving at the transfer
                n_out_valid = 1'b1;
                n_removed   = r_rd_data;
                n_status    = adq_pkg::ST_DONE;
                n_state     = adq_pkg::S_IDLE;
            end
            default: begin
                n_state = adq_pkg::S_IDLE;
            end
        endcase
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_op.insert_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= adq_pkg::S_IDLE;
            r_front     <= '0;
            r_rear      <= '0;
            r_empty     <= 1'b1;
            r_cap       <= adq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_removed <= n_removed;
        r_status  <= n_status;
    end

endmodule
